// ===== rtl/core/aid_table_record_parser_core_assert.svh =====
// aid_table_record_parser_core_assert.svh
// Assertion macros for the record parser core; the including module provides clk_i and rst_ni.
`ifndef AID_TABLE_RECORD_PARSER_CORE_ASSERT_SVH
`define AID_TABLE_RECORD_PARSER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ATRP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ATRP_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ATRP_ASSERT(name, prop, msg)
`define ATRP_ASSERT_NEVER(name, cond, msg)
`endif
`endif

// ===== rtl/core/atrp_pkg.sv =====
// atrp_pkg.sv
// Types, constants and the kernel lookup table shared by the record parser core.
// No dependencies.
package atrp_pkg;

  localparam int unsigned MAX_RECORDS  = 32;
  localparam int unsigned MAX_ID_LEN   = 16;
  localparam int unsigned MAX_LIST_LEN = 64;

  localparam int unsigned RID_LEN     = 5;
  localparam int unsigned NUM_RID     = 6;
  localparam int unsigned CODE_LEN    = 5;
  localparam int unsigned CODE_BYTES  = 3 * CODE_LEN;
  localparam int unsigned CODE_AW     = $clog2(CODE_BYTES);
  localparam int unsigned FLOOR_BYTES = 4;
  localparam logic [7:0]  CODE_FILL   = 8'hFF;

  localparam logic [8*RID_LEN-1:0] KNOWN_RID [NUM_RID] = '{
    40'hA000000004, 40'hA000000003, 40'hA000000025,
    40'hA000000152, 40'hA000000651, 40'hA000000604
  };
  localparam logic [7:0] RID_KERNEL [NUM_RID] = '{8'd2, 8'd3, 8'd4, 8'd6, 8'd7, 8'd2};

  typedef enum logic [3:0] {
    PH_IDLEN  = 4'd0,
    PH_ID     = 4'd1,
    PH_CTLS   = 4'd2,
    PH_KERNEL = 4'd3,
    PH_CODES  = 4'd4,
    PH_FLOOR  = 4'd5,
    PH_DLEN   = 4'd6,
    PH_DDATA  = 4'd7,
    PH_TLEN   = 4'd8,
    PH_TDATA  = 4'd9
  } phase_e;

  typedef enum logic [3:0] {
    KIND_AID         = 4'd0,
    KIND_CTLS        = 4'd1,
    KIND_KERNEL      = 4'd2,
    KIND_TAC_DENIAL  = 4'd3,
    KIND_TAC_ONLINE  = 4'd4,
    KIND_TAC_DEFAULT = 4'd5,
    KIND_FLOOR       = 4'd6,
    KIND_DDOL        = 4'd7,
    KIND_TDOL        = 4'd8,
    KIND_RECORD_END  = 4'd9,
    KIND_BUFFER_DONE = 4'd10
  } kind_e;

  // Parser state held between beats
  typedef struct packed {
    phase_e              phase;
    logic [7:0]          fcnt;
    logic [7:0]          flen;
    logic [8*RID_LEN-1:0] aid_prefix;
    logic [4:0]          aid_len;
    logic                ctls;
    logic                any_nz;
    logic [31:0]         floor_acc;
    logic [5:0]          rec_done;
    logic [15:0]         byte_pos;
    logic [15:0]         committed;
    logic                stopped;
  } st_t;

  localparam st_t ST_RESET = '{phase: PH_IDLEN, default: '0};

  // Results caused by one accepted beat
  typedef struct packed {
    logic        fld_vld;
    kind_e       fld_kind;
    logic [7:0]  fld_index;
    logic [31:0] fld_value;
    logic [5:0]  rec_field;
    logic        burst;
    logic        burst_ff;
    logic        recend;
    logic        done;
    logic [5:0]  done_rec;
    logic [15:0] done_consumed;
    logic        done_err;
  } pend_t;

  typedef struct packed {
    logic               we;
    logic [CODE_AW-1:0] addr;
    logic [7:0]         data;
  } code_wr_t;

  function automatic logic [7:0] lookup_kernel(logic [8*RID_LEN-1:0] prefix,
                                               logic [4:0] len);
    logic [7:0] kid;
    kid = '0;
    if (len >= 5'(RID_LEN)) begin
      for (int i = 0; i < NUM_RID; i++) begin
        if (prefix == KNOWN_RID[i]) kid = RID_KERNEL[i];
      end
    end
    return kid;
  endfunction

endpackage

// ===== rtl/core/atrp_in_if.sv =====
// atrp_in_if.sv
// Input byte channel of the record parser: valid/ready with byte and end marker.
// No dependencies.
interface atrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

// ===== rtl/core/atrp_out_if.sv =====
// atrp_out_if.sv
// Result channel of the record parser: valid/ready with one tagged field result.
// No dependencies.
interface atrp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_kind;
  logic [7:0]  byte_index;
  logic [31:0] field_value;
  logic [5:0]  record_index;
  logic [15:0] consumed_bytes;
  logic        error_status;
  logic        run_last;

  modport source (output valid, output field_kind, output byte_index, output field_value,
                  output record_index, output consumed_bytes, output error_status,
                  output run_last, input ready);
  modport sink   (input valid, input field_kind, input byte_index, input field_value,
                  input record_index, input consumed_bytes, input error_status,
                  input run_last, output ready);
endinterface

// ===== rtl/core/atrp_parse.sv =====
// atrp_parse.sv
// Next-state and result decode for one buffer byte of the record parser.
// Depends on atrp_pkg.
module atrp_parse (
  input  atrp_pkg::st_t     state_i,
  input  logic [7:0]        data_byte_i,
  input  logic              buffer_end_i,
  output atrp_pkg::st_t     state_o,
  output atrp_pkg::pend_t   pend_o,
  output atrp_pkg::code_wr_t code_wr_o
);

  logic [15:0] bp_n;
  logic [7:0]  cnt_n;
  logic [5:0]  rec_n;
  logic [7:0]  kid;
  logic        any_nz_n;
  logic [31:0] floor_n;
  logic [5:0]  aid_sh;
  logic        fin;

  always_comb begin
    state_o   = state_i;
    pend_o    = '0;
    code_wr_o = '0;
    fin       = 1'b0;
    bp_n      = (state_i.byte_pos != '1) ? state_i.byte_pos + 16'd1 : state_i.byte_pos;
    cnt_n     = state_i.fcnt + 8'd1;
    rec_n     = state_i.rec_done + 6'd1;
    kid       = (state_i.ctls && data_byte_i == 8'd0)
                ? atrp_pkg::lookup_kernel(state_i.aid_prefix, state_i.aid_len)
                : data_byte_i;
    any_nz_n  = state_i.any_nz | (data_byte_i != 8'd0);
    floor_n   = {state_i.floor_acc[23:0], data_byte_i};
    aid_sh    = {3'd4 - state_i.fcnt[2:0], 3'b000};

    state_o.byte_pos = bp_n;
    pend_o.rec_field = state_i.rec_done;

    if (buffer_end_i && bp_n == 16'd1) begin
      // one-byte buffer
      pend_o.done     = 1'b1;
      pend_o.done_err = 1'b1;
      state_o         = atrp_pkg::ST_RESET;
    end else begin
      if (!state_i.stopped) begin
        unique case (state_i.phase)
          atrp_pkg::PH_IDLEN: begin
            state_o.committed = bp_n;
            if (data_byte_i == 8'd0 || data_byte_i > 8'(atrp_pkg::MAX_ID_LEN)) begin
              state_o.stopped = 1'b1;
            end else begin
              state_o.flen       = data_byte_i;
              state_o.fcnt       = '0;
              state_o.aid_prefix = '0;
              state_o.aid_len    = data_byte_i[4:0];
              state_o.phase      = atrp_pkg::PH_ID;
            end
          end
          atrp_pkg::PH_ID: begin
            if (state_i.fcnt < 8'(atrp_pkg::RID_LEN)) begin
              state_o.aid_prefix = state_i.aid_prefix
                                 | (40'(data_byte_i) << aid_sh);
            end
            pend_o.fld_vld   = 1'b1;
            pend_o.fld_kind  = atrp_pkg::KIND_AID;
            pend_o.fld_index = state_i.fcnt;
            pend_o.fld_value = 32'(data_byte_i);
            state_o.fcnt     = cnt_n;
            if (cnt_n >= state_i.flen) begin
              state_o.committed = bp_n;
              state_o.phase     = atrp_pkg::PH_CTLS;
            end
          end
          atrp_pkg::PH_CTLS: begin
            state_o.ctls      = (data_byte_i != 8'd0);
            state_o.committed = bp_n;
            pend_o.fld_vld    = 1'b1;
            pend_o.fld_kind   = atrp_pkg::KIND_CTLS;
            pend_o.fld_value  = {31'b0, data_byte_i != 8'd0};
            state_o.phase     = atrp_pkg::PH_KERNEL;
          end
          atrp_pkg::PH_KERNEL: begin
            state_o.committed = bp_n;
            pend_o.fld_vld    = 1'b1;
            pend_o.fld_kind   = atrp_pkg::KIND_KERNEL;
            pend_o.fld_value  = 32'(kid);
            state_o.fcnt      = '0;
            state_o.any_nz    = 1'b0;
            state_o.phase     = atrp_pkg::PH_CODES;
          end
          atrp_pkg::PH_CODES: begin
            code_wr_o.we   = (state_i.fcnt < 8'(atrp_pkg::CODE_BYTES));
            code_wr_o.addr = state_i.fcnt[atrp_pkg::CODE_AW-1:0];
            code_wr_o.data = data_byte_i;
            state_o.any_nz = any_nz_n;
            state_o.fcnt   = cnt_n;
            if (cnt_n == 8'(atrp_pkg::CODE_LEN) || cnt_n == 8'(2 * atrp_pkg::CODE_LEN)
                || cnt_n == 8'(atrp_pkg::CODE_BYTES)) begin
              state_o.committed = bp_n;
            end
            if (cnt_n >= 8'(atrp_pkg::CODE_BYTES)) begin
              pend_o.burst      = 1'b1;
              pend_o.burst_ff   = !any_nz_n;
              state_o.fcnt      = '0;
              state_o.floor_acc = '0;
              state_o.phase     = atrp_pkg::PH_FLOOR;
            end
          end
          atrp_pkg::PH_FLOOR: begin
            state_o.floor_acc = floor_n;
            state_o.fcnt      = cnt_n;
            if (cnt_n >= 8'(atrp_pkg::FLOOR_BYTES)) begin
              state_o.committed = bp_n;
              pend_o.fld_vld    = 1'b1;
              pend_o.fld_kind   = atrp_pkg::KIND_FLOOR;
              pend_o.fld_value  = floor_n;
              state_o.phase     = atrp_pkg::PH_DLEN;
            end
          end
          atrp_pkg::PH_DLEN, atrp_pkg::PH_TLEN: begin
            state_o.committed = bp_n;
            if (data_byte_i > 8'(atrp_pkg::MAX_LIST_LEN)) begin
              state_o.stopped = 1'b1;
            end else if (data_byte_i == 8'd0) begin
              if (state_i.phase == atrp_pkg::PH_DLEN) state_o.phase = atrp_pkg::PH_TLEN;
              else fin = 1'b1;
            end else begin
              state_o.flen  = data_byte_i;
              state_o.fcnt  = '0;
              state_o.phase = (state_i.phase == atrp_pkg::PH_DLEN) ? atrp_pkg::PH_DDATA
                                                                    : atrp_pkg::PH_TDATA;
            end
          end
          atrp_pkg::PH_DDATA, atrp_pkg::PH_TDATA: begin
            pend_o.fld_vld   = 1'b1;
            pend_o.fld_kind  = (state_i.phase == atrp_pkg::PH_DDATA) ? atrp_pkg::KIND_DDOL
                                                                      : atrp_pkg::KIND_TDOL;
            pend_o.fld_index = state_i.fcnt;
            pend_o.fld_value = 32'(data_byte_i);
            state_o.fcnt     = cnt_n;
            if (cnt_n >= state_i.flen) begin
              state_o.committed = bp_n;
              if (state_i.phase == atrp_pkg::PH_DDATA) state_o.phase = atrp_pkg::PH_TLEN;
              else fin = 1'b1;
            end
          end
          default: state_o.stopped = 1'b1;
        endcase
      end

      // close the record and stop at the record limit
      if (fin) begin
        pend_o.recend    = 1'b1;
        state_o.rec_done = rec_n;
        state_o.phase    = atrp_pkg::PH_IDLEN;
        if (rec_n >= 6'(atrp_pkg::MAX_RECORDS)) state_o.stopped = 1'b1;
      end

      if (buffer_end_i) begin
        pend_o.done          = 1'b1;
        pend_o.done_rec      = state_o.rec_done;
        pend_o.done_consumed = state_o.committed;
        state_o              = atrp_pkg::ST_RESET;
      end
    end
  end

endmodule

// ===== rtl/core/aid_table_record_parser_core.sv =====
// Record parser core: one buffer byte per input beat, tagged field results out.
// An accepted byte's results go to the output register in turn: its field result or
// the action-code burst (each code byte read from the code store, then registered),
// then record_end and buffer_done; no new byte is taken until the last one is loaded.
// Output back-pressure adds stall cycles. Reset clears parser state and handshake; the
// code store is not cleared.
`include "aid_table_record_parser_core_assert.svh"

module aid_table_record_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  atrp_in_if.sink    in_i,
  atrp_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIELD,
    S_RD,
    S_BURST,
    S_RECEND,
    S_DONE
  } seq_e;

  typedef struct packed {
    atrp_pkg::kind_e kind;
    logic [7:0]      index;
    logic [31:0]     value;
    logic [5:0]      rec;
    logic [15:0]     consumed;
    logic            err;
    logic            last;
  } res_t;

  localparam logic [atrp_pkg::CODE_AW-1:0] CodeLast = atrp_pkg::CODE_AW'(atrp_pkg::CODE_BYTES - 1);
  localparam logic [atrp_pkg::CODE_AW-1:0] CodeMid  = atrp_pkg::CODE_AW'(atrp_pkg::CODE_LEN);
  localparam logic [atrp_pkg::CODE_AW-1:0] CodeHigh = atrp_pkg::CODE_AW'(2 * atrp_pkg::CODE_LEN);

  seq_e                        seq_q;
  atrp_pkg::st_t               st_q, st_d;
  atrp_pkg::pend_t             pend_q, pend_d;
  atrp_pkg::code_wr_t          code_wr;
  logic [atrp_pkg::CODE_AW-1:0] burst_k_q;
  logic [7:0]                  code_rd_q;
  logic [7:0]                  code_mem [atrp_pkg::CODE_BYTES];
  res_t                        out_q;
  logic                        out_valid_q;
  logic                        in_acc, out_free, out_load;
  seq_e                        first_s, after_fld, after_rec;
  res_t                        res_fld, res_burst, res_rec, res_done;

  atrp_parse u_parse (
    .state_i     (st_q),
    .data_byte_i (in_i.data_byte),
    .buffer_end_i(in_i.buffer_end),
    .state_o     (st_d),
    .pend_o      (pend_d),
    .code_wr_o   (code_wr)
  );

  assign in_i.ready = (seq_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  // a result beat is loaded into the output register this cycle
  assign out_load   = out_free && (seq_q == S_FIELD || seq_q == S_BURST ||
                                   seq_q == S_RECEND || seq_q == S_DONE);

  always_comb begin
    after_rec = pend_q.done ? S_DONE : S_IDLE;
    after_fld = pend_q.recend ? S_RECEND : after_rec;
    priority if (pend_d.fld_vld) first_s = S_FIELD;
    else if (pend_d.burst)       first_s = S_RD;
    else if (pend_d.recend)      first_s = S_RECEND;
    else if (pend_d.done)        first_s = S_DONE;
    else                         first_s = S_IDLE;
  end

  always_comb begin
    res_fld = '{kind: pend_q.fld_kind, index: pend_q.fld_index, value: pend_q.fld_value,
                rec: pend_q.rec_field, consumed: '0, err: 1'b0,
                last: !(pend_q.recend || pend_q.done)};

    res_burst          = '0;
    res_burst.rec      = pend_q.rec_field;
    res_burst.value    = 32'(pend_q.burst_ff ? atrp_pkg::CODE_FILL : code_rd_q);
    res_burst.last     = (burst_k_q == CodeLast) && !pend_q.done;
    priority if (burst_k_q < CodeMid) begin
      res_burst.kind  = atrp_pkg::KIND_TAC_DENIAL;
      res_burst.index = 8'(burst_k_q);
    end else if (burst_k_q < CodeHigh) begin
      res_burst.kind  = atrp_pkg::KIND_TAC_ONLINE;
      res_burst.index = 8'(burst_k_q - CodeMid);
    end else begin
      res_burst.kind  = atrp_pkg::KIND_TAC_DEFAULT;
      res_burst.index = 8'(burst_k_q - CodeHigh);
    end

    res_rec = '{kind: atrp_pkg::KIND_RECORD_END, index: '0, value: '0,
                rec: pend_q.rec_field, consumed: '0, err: 1'b0, last: !pend_q.done};

    res_done = '{kind: atrp_pkg::KIND_BUFFER_DONE, index: '0, value: '0,
                 rec: pend_q.done_rec, consumed: pend_q.done_consumed,
                 err: pend_q.done_err, last: 1'b1};
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= S_IDLE;
      out_valid_q <= 1'b0;
      burst_k_q   <= '0;
      pend_q      <= '0;
      out_q       <= '0;
    end else begin
      if (out_o.ready && !out_load) out_valid_q <= 1'b0;
      unique case (seq_q)
        S_IDLE: begin
          if (in_acc) begin
            pend_q    <= pend_d;
            burst_k_q <= '0;
            seq_q     <= first_s;
          end
        end
        S_FIELD: begin
          if (out_free) begin
            out_q       <= res_fld;
            out_valid_q <= 1'b1;
            seq_q       <= after_fld;
          end
        end
        S_RD: seq_q <= S_BURST;
        S_BURST: begin
          if (out_free) begin
            out_q       <= res_burst;
            out_valid_q <= 1'b1;
            if (burst_k_q == CodeLast) begin
              seq_q <= after_rec;
            end else begin
              burst_k_q <= burst_k_q + 1'b1;
              seq_q     <= S_RD;
            end
          end
        end
        S_RECEND: begin
          if (out_free) begin
            out_q       <= res_rec;
            out_valid_q <= 1'b1;
            seq_q       <= after_rec;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_q       <= res_done;
            out_valid_q <= 1'b1;
            seq_q       <= S_IDLE;
          end
        end
        default: seq_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= atrp_pkg::ST_RESET;
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  // action-code store: written per code beat, read back one byte per burst step
  always_ff @(posedge clk_i) begin
    if (in_acc && code_wr.we) code_mem[code_wr.addr] <= code_wr.data;
    if (seq_q == S_RD) code_rd_q <= code_mem[burst_k_q];
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.field_kind     = out_q.kind;
  assign out_o.byte_index     = out_q.index;
  assign out_o.field_value    = out_q.value;
  assign out_o.record_index   = out_q.rec;
  assign out_o.consumed_bytes = out_q.consumed;
  assign out_o.error_status   = out_q.err;
  assign out_o.run_last       = out_q.last;

  `ATRP_ASSERT(a_end_resets, (in_acc && in_i.buffer_end) |=> (st_q.byte_pos == '0 && st_q.rec_done == '0 && !st_q.stopped), "parser state not cleared after buffer end")
  `ATRP_ASSERT(a_done_is_last, (out_valid_q && out_q.kind == atrp_pkg::KIND_BUFFER_DONE) |-> out_q.last, "buffer_done beat without run_last")
  `ATRP_ASSERT_NEVER(a_burst_range, (seq_q == S_BURST || seq_q == S_RD) && burst_k_q > CodeLast, "code store index out of range")
  `ATRP_ASSERT_NEVER(a_rec_limit, st_q.rec_done > 6'(atrp_pkg::MAX_RECORDS), "record count beyond limit")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the record parser core: byte-stream stimulus in, tagged field results out.
// Depends on atrp_pkg, atrp_in_if, atrp_out_if and aid_table_record_parser_core.
`timescale 1ns / 1ps

module tb_top;
  import atrp_pkg::*;

  localparam int CODES_ZERO  = 0;
  localparam int CODES_ONE   = 1;
  localparam int CODES_MIXED = 2;
  localparam int NUM_KNOWN   = 6;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
  } buf_byte_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  idx;
    logic [31:0] value;
    logic [5:0]  rec;
    logic [15:0] consumed;
    logic        err;
    logic        run_last;
  } field_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  atrp_in_if  in_if ();
  atrp_out_if out_if ();

  aid_table_record_parser_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  buf_byte_t  byte_q [$];
  logic [7:0] buf_bytes [$];
  field_res_t fields_due [$];
  field_res_t step_out [$];

  int n_errors      = 0;
  int fields_seen   = 0;
  int records_seen  = 0;
  int bytes_sent    = 0;
  int bytes_queued  = 0;
  int buffers_sent  = 0;
  bit idle_on       = 1'b1;
  bit rx_hold       = 1'b0;
  int tx_gap        = 0;
  int rx_stall      = 0;
  buf_byte_t tx_cur;
  event hold_start;

  // ---------------------------------------------------------------------------
  // Parser state mirror
  // ---------------------------------------------------------------------------
  phase_e      p_phase;
  logic [7:0]  p_cnt;
  logic [7:0]  p_len;
  logic [39:0] p_prefix;
  logic [4:0]  p_aidlen;
  logic        p_ctls;
  logic        p_anynz;
  logic [7:0]  p_codes [CODE_BYTES];
  logic [31:0] p_floor;
  logic [5:0]  p_recs;
  logic [15:0] p_pos;
  logic [15:0] p_commit;
  logic        p_stopped;

  // Known RIDs with the kernel each maps to: {kernel, rid}
  function automatic logic [47:0] rid_entry(int sel);
    case (sel)
      0:       return {8'd2, 40'hA0_00_00_00_04};
      1:       return {8'd3, 40'hA0_00_00_00_03};
      2:       return {8'd4, 40'hA0_00_00_00_25};
      3:       return {8'd6, 40'hA0_00_00_01_52};
      4:       return {8'd7, 40'hA0_00_00_06_51};
      default: return {8'd2, 40'hA0_00_00_06_04};
    endcase
  endfunction

  function automatic logic [7:0] resolve_kernel();
    logic [47:0] entry;
    logic [7:0]  kid;
    kid = 8'd0;
    if (p_aidlen >= 5) begin
      for (int i = 0; i < NUM_KNOWN; i++) begin
        entry = rid_entry(i);
        if (entry[39:0] == p_prefix) kid = entry[47:40];
      end
    end
    return kid;
  endfunction

  function automatic void clear_parser();
    p_phase   = PH_IDLEN;
    p_cnt     = '0;
    p_len     = '0;
    p_prefix  = '0;
    p_aidlen  = '0;
    p_ctls    = 1'b0;
    p_anynz   = 1'b0;
    p_floor   = '0;
    p_recs    = '0;
    p_pos     = '0;
    p_commit  = '0;
    p_stopped = 1'b0;
  endfunction

  function automatic void push_field(kind_e k, logic [7:0] idx, logic [31:0] v,
                                     logic [15:0] cons, logic err);
    field_res_t f;
    f.kind     = k;
    f.idx      = idx;
    f.value    = v;
    f.rec      = p_recs;
    f.consumed = cons;
    f.err      = err;
    f.run_last = 1'b0;
    step_out.push_back(f);
  endfunction

  function automatic void close_record();
    push_field(KIND_RECORD_END, 8'd0, 32'd0, 16'd0, 1'b0);
    p_recs  = p_recs + 6'd1;
    p_phase = PH_IDLEN;
    if (p_recs >= MAX_RECORDS) p_stopped = 1'b1;
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic [7:0] kid;
    kind_e      lk;
    case (p_phase)
      PH_IDLEN: begin
        p_commit = p_pos;
        if (b == 8'd0 || b > MAX_ID_LEN) begin
          p_stopped = 1'b1;
        end else begin
          p_len    = b;
          p_cnt    = '0;
          p_prefix = '0;
          p_aidlen = b[4:0];
          p_phase  = PH_ID;
        end
      end
      PH_ID: begin
        // the first five id bytes end up left-aligned after five shifts
        if (p_cnt < 5) p_prefix = {p_prefix[31:0], b};
        push_field(KIND_AID, p_cnt, {24'd0, b}, 16'd0, 1'b0);
        p_cnt = p_cnt + 8'd1;
        if (p_cnt >= p_len) begin
          p_commit = p_pos;
          p_phase  = PH_CTLS;
        end
      end
      PH_CTLS: begin
        p_ctls   = (b != 8'd0);
        p_commit = p_pos;
        push_field(KIND_CTLS, 8'd0, {31'd0, p_ctls}, 16'd0, 1'b0);
        p_phase  = PH_KERNEL;
      end
      PH_KERNEL: begin
        kid = b;
        if (p_ctls && b == 8'd0) kid = resolve_kernel();
        p_commit = p_pos;
        push_field(KIND_KERNEL, 8'd0, {24'd0, kid}, 16'd0, 1'b0);
        p_cnt   = '0;
        p_anynz = 1'b0;
        p_phase = PH_CODES;
      end
      PH_CODES: begin
        p_codes[p_cnt] = b;
        if (b != 8'd0) p_anynz = 1'b1;
        p_cnt = p_cnt + 8'd1;
        if (p_cnt % 5 == 0) p_commit = p_pos;
        if (p_cnt >= CODE_BYTES) begin
          for (int k = 0; k < CODE_BYTES; k++) begin
            if (k < 5) lk = KIND_TAC_DENIAL;
            else if (k < 10) lk = KIND_TAC_ONLINE;
            else lk = KIND_TAC_DEFAULT;
            push_field(lk, 8'(k % 5), {24'd0, p_anynz ? p_codes[k] : 8'hFF}, 16'd0, 1'b0);
          end
          p_cnt   = '0;
          p_floor = '0;
          p_phase = PH_FLOOR;
        end
      end
      PH_FLOOR: begin
        p_floor = {p_floor[23:0], b};
        p_cnt   = p_cnt + 8'd1;
        if (p_cnt >= 4) begin
          p_commit = p_pos;
          push_field(KIND_FLOOR, 8'd0, p_floor, 16'd0, 1'b0);
          p_phase = PH_DLEN;
        end
      end
      PH_DLEN, PH_TLEN: begin
        p_commit = p_pos;
        if (b > MAX_LIST_LEN) begin
          p_stopped = 1'b1;
        end else if (b == 8'd0) begin
          if (p_phase == PH_DLEN) p_phase = PH_TLEN;
          else close_record();
        end else begin
          p_len = b;
          p_cnt = '0;
          if (p_phase == PH_DLEN) p_phase = PH_DDATA;
          else p_phase = PH_TDATA;
        end
      end
      PH_DDATA, PH_TDATA: begin
        if (p_phase == PH_DDATA) lk = KIND_DDOL;
        else lk = KIND_TDOL;
        push_field(lk, p_cnt, {24'd0, b}, 16'd0, 1'b0);
        p_cnt = p_cnt + 8'd1;
        if (p_cnt >= p_len) begin
          p_commit = p_pos;
          if (p_phase == PH_DDATA) p_phase = PH_TLEN;
          else close_record();
        end
      end
      default: p_stopped = 1'b1;
    endcase
  endfunction

  // Work out every field result one accepted byte causes and queue them
  function automatic void predict_fields(logic [7:0] b, logic is_end);
    field_res_t f;
    step_out.delete();
    if (p_pos != 16'hFFFF) p_pos = p_pos + 16'd1;
    if (is_end && p_pos == 16'd1) begin
      push_field(KIND_BUFFER_DONE, 8'd0, 32'd0, 16'd0, 1'b1);
    end else begin
      if (!p_stopped) parse_byte(b);
      if (is_end) push_field(KIND_BUFFER_DONE, 8'd0, 32'd0, p_commit, 1'b0);
    end
    if (is_end) clear_parser();
    if (step_out.size() != 0) begin
      f = step_out.pop_back();
      f.run_last = 1'b1;
      step_out.push_back(f);
    end
    foreach (step_out[i]) fields_due.push_back(step_out[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver and monitor
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin : byte_driver
    logic nv;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      tx_gap      <= 0;
    end else begin
      nv = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        predict_fields(tx_cur.data, tx_cur.is_end);
        bytes_sent = bytes_sent + 1;
        nv = 1'b0;
      end
      if (!nv) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
        end else if (byte_q.size() != 0) begin
          tx_cur = byte_q.pop_front();
          in_if.data_byte  <= tx_cur.data;
          in_if.buffer_end <= tx_cur.is_end;
          nv = 1'b1;
          if (idle_on) tx_gap <= pick_gap();
        end
      end
      // hold valid across back-to-back beats: one assignment per edge
      in_if.valid <= nv;
    end
  end

  task automatic cmp_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      n_errors = n_errors + 1;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : field_monitor
    field_res_t w;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_stall     <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (fields_due.size() == 0) begin
          n_errors = n_errors + 1;
          $display("%0t ns: unexpected result, expected none, got kind %0d value %0h",
                   $time, out_if.field_kind, out_if.field_value);
        end else begin
          w = fields_due.pop_front();
          cmp_field("field_kind", 32'(w.kind), 32'(out_if.field_kind));
          cmp_field("byte_index", 32'(w.idx), 32'(out_if.byte_index));
          cmp_field("field_value", w.value, out_if.field_value);
          cmp_field("record_index", 32'(w.rec), 32'(out_if.record_index));
          cmp_field("consumed_bytes", 32'(w.consumed), 32'(out_if.consumed_bytes));
          cmp_field("error_status", 32'(w.err), 32'(out_if.error_status));
          cmp_field("run_last", 32'(w.run_last), 32'(out_if.run_last));
          fields_seen = fields_seen + 1;
          if (w.kind == KIND_RECORD_END) records_seen = records_seen + 1;
        end
      end
      if (rx_hold) begin
        out_if.ready <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall     <= rx_stall - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (idle_on) rx_stall <= pick_gap();
      end
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering bytes
  initial begin : rx_holdoff
    @(hold_start);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : run_limit
    #(30_000_000);
    $display("Timeout with %0d results outstanding", fields_due.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic ship_buffer();
    buf_byte_t bb;
    foreach (buf_bytes[i]) begin
      bb.data   = buf_bytes[i];
      bb.is_end = (i == buf_bytes.size() - 1);
      byte_q.push_back(bb);
    end
    bytes_queued = bytes_queued + buf_bytes.size();
    buffers_sent = buffers_sent + 1;
    buf_bytes.delete();
  endtask

  task automatic add_record(input int id_len, input int rid_sel, input bit ctls_on,
                            input bit kid_zero, input int codes_mode,
                            input int dlen, input int tlen);
    logic [47:0] entry;
    logic [39:0] rid;
    logic [31:0] lim;
    int          hot;
    int          r;
    buf_bytes.push_back(8'(id_len));
    if (id_len == 0 || id_len > MAX_ID_LEN) return;
    entry = rid_entry(rid_sel);
    if (rid_sel < NUM_KNOWN) rid = entry[39:0];
    else if (rid_sel == NUM_KNOWN) rid = {32'hA000_0000, 8'($urandom)};
    else rid = {8'($urandom), 32'($urandom)};
    for (int i = 0; i < id_len; i++)
      buf_bytes.push_back(i < 5 ? rid[8*(4-i) +: 8] : 8'($urandom));
    if (!ctls_on) buf_bytes.push_back(8'd0);
    else if ($urandom_range(0, 3) == 0) buf_bytes.push_back(8'($urandom_range(1, 255)));
    else buf_bytes.push_back(8'd1);
    buf_bytes.push_back(kid_zero ? 8'd0 : 8'($urandom_range(1, 255)));
    hot = $urandom_range(0, CODE_BYTES - 1);
    for (int i = 0; i < CODE_BYTES; i++) begin
      case (codes_mode)
        CODES_ZERO: buf_bytes.push_back(8'd0);
        CODES_ONE:  buf_bytes.push_back(i == hot ? 8'($urandom_range(1, 255)) : 8'd0);
        default:    buf_bytes.push_back($urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom));
      endcase
    end
    r = $urandom_range(0, 9);
    lim = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
    for (int i = 3; i >= 0; i--) buf_bytes.push_back(lim[8*i +: 8]);
    buf_bytes.push_back(8'(dlen));
    if (dlen > MAX_LIST_LEN) return;
    repeat (dlen) buf_bytes.push_back(8'($urandom));
    buf_bytes.push_back(8'(tlen));
    if (tlen > MAX_LIST_LEN) return;
    repeat (tlen) buf_bytes.push_back(8'($urandom));
  endtask

  function automatic int pick_list_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 88) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 63);
    return MAX_LIST_LEN;
  endfunction

  function automatic int pick_codes_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return CODES_ZERO;
    if (r == 2) return CODES_ONE;
    return CODES_MIXED;
  endfunction

  task automatic add_random_record();
    int r;
    int id_len;
    r = $urandom_range(0, 99);
    if (r < 60) id_len = $urandom_range(5, 8);
    else if (r < 85) id_len = $urandom_range(9, MAX_ID_LEN);
    else id_len = $urandom_range(1, 4);
    add_record(id_len, $urandom_range(0, NUM_KNOWN + 1), $urandom_range(0, 1),
               $urandom_range(0, 2) != 0, pick_codes_mode(), pick_list_len(), pick_list_len());
  endtask

  task automatic add_noise(input int n);
    repeat (n) buf_bytes.push_back(8'($urandom));
  endtask

  task automatic wait_drained();
    // sample away from the driving edge so queue and valid have settled
    while (byte_q.size() != 0 || in_if.valid || fields_due.size() != 0) @(negedge clk);
    // bytes that cause no result may still be in flight
    repeat (6) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [63:0] lead;
    int          r;
    int          start;
    int          cut;
    int          rand_start;

    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'd0;
    in_if.buffer_end = 1'b0;
    out_if.ready     = 1'b0;
    clear_parser();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte buffers: error report only
    buf_bytes.push_back(8'h00);
    ship_buffer();
    buf_bytes.push_back(8'hFF);
    ship_buffer();
    // zero and oversized id lengths stop at once
    buf_bytes.push_back(8'd0);
    buf_bytes.push_back(8'h5A);
    ship_buffer();
    buf_bytes.push_back(8'(MAX_ID_LEN + 1));
    buf_bytes.push_back(8'hA5);
    ship_buffer();
    // known RID with ctls set and kernel zero, all-zero action codes, top floor limit
    lead = 64'h05_A0_00_00_00_04_01_00;
    for (int i = 7; i >= 0; i--) buf_bytes.push_back(lead[8*i +: 8]);
    repeat (CODE_BYTES) buf_bytes.push_back(8'h00);
    repeat (4) buf_bytes.push_back(8'hFF);
    buf_bytes.push_back(8'd1);
    buf_bytes.push_back(8'hFF);
    buf_bytes.push_back(8'd0);
    ship_buffer();
    wait_drained();

    rand_start = bytes_queued;
    while (bytes_queued - rand_start < 300) begin
      idle_on <= ($urandom_range(0, 4) != 0);
      r = $urandom_range(0, 99);
      if (r < 50) begin
        repeat ($urandom_range(1, 3)) add_random_record();
      end else if (r < 65) begin
        // end the buffer inside a record
        repeat ($urandom_range(0, 2)) add_random_record();
        start = buf_bytes.size();
        add_random_record();
        cut = $urandom_range(start + 1, buf_bytes.size() - 1);
        while (buf_bytes.size() > cut) void'(buf_bytes.pop_back());
      end else if (r < 80) begin
        repeat ($urandom_range(0, 2)) add_random_record();
        case ($urandom_range(0, 2))
          0: add_record($urandom_range(0, 1) ? 0 : $urandom_range(MAX_ID_LEN + 1, 255),
                        0, 0, 0, CODES_MIXED, 0, 0);
          1: add_record($urandom_range(1, MAX_ID_LEN), $urandom_range(0, NUM_KNOWN + 1), 1, 1,
                        pick_codes_mode(), $urandom_range(MAX_LIST_LEN + 1, 255), 0);
          default: add_record($urandom_range(1, MAX_ID_LEN), $urandom_range(0, NUM_KNOWN + 1),
                              1, 0, pick_codes_mode(), pick_list_len(),
                              $urandom_range(MAX_LIST_LEN + 1, 255));
        endcase
        add_noise($urandom_range(0, 4));
      end else if (r < 87) begin
        add_noise(1);
      end else begin
        add_noise($urandom_range(2, 12));
      end
      ship_buffer();
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    wait_drained();

    // back-pressure: results pile up while the receiver holds off
    idle_on <= 1'b1;
    repeat (4) add_record($urandom_range(5, 8), $urandom_range(0, NUM_KNOWN - 1), 1, 1,
                          CODES_MIXED, $urandom_range(1, 4), $urandom_range(1, 4));
    ship_buffer();
    -> hold_start;
    wait_drained();
    repeat (20) @(posedge clk);

    if (fields_due.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, fields_due.size());
      n_errors = n_errors + fields_due.size();
    end
    $display("Sent %0d bytes in %0d buffers; checked %0d field results, %0d records closed.",
             bytes_sent, buffers_sent, fields_seen, records_seen);
    $display("Covered one-byte and bad-length buffers, truncated records, kernel lookup,");
    $display("filled action codes and a long receiver hold-off with the input stalled.");
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/atrp_pkg.sv
rtl/core/atrp_in_if.sv
rtl/core/atrp_out_if.sv
rtl/core/atrp_parse.sv
rtl/core/aid_table_record_parser_core.sv
tb/tb_top.sv
